>>> sv/ssba_pkg.sv
package ssba_pkg;

  // Fixed field widths
  localparam int SLOT_W   = 12;
  localparam int REQ_W    = 7;
  localparam int STATUS_W = 2;

  // Reciprocal division of a slot number by the word size
  localparam int DIV_SHIFT = SLOT_W + REQ_W;

  // Default sizes
  localparam int MAP_WORDS_DEF   = 64;
  localparam int WORD_BITS_DEF   = 64;
  localparam int MAX_REQUEST_DEF = 64;

  // Action codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REFUSED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_USED = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;        // write one word of the reset sweep
    logic load;         // capture the accepted word
    logic read_ptr;     // read the map word at the pointer
    logic advance;      // step the pointer and read the next word
    logic take;         // claim lowest clear bit, emit slot
    logic refuse_emit;  // emit a refusal
    logic free_mul;     // slot to word index
    logic free_rd;      // bit index, read the word
    logic free_emit;    // clear the bit if set, emit echo
  } ssba_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic act_free;
    logic refuse;
    logic cur_full;
    logic take_last;
    logic out_space;
  } ssba_sts_t;

endpackage

>>> sv/ssba_ifs.sv
interface ssba_in_if import ssba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [REQ_W-1:0]  request_size;
  logic [SLOT_W-1:0] slot_to_free;

  modport source (output valid, action, request_size, slot_to_free, input ready);
  modport sink   (input valid, action, request_size, slot_to_free, output ready);
endinterface

interface ssba_out_if import ssba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   slot;
  logic [STATUS_W-1:0] status;
  logic                last;

  modport source (output valid, slot, status, last, input ready);
  modport sink   (input valid, slot, status, last, output ready);
endinterface

>>> sv/ssba_ram.sv
module ssba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/ssba_ctrl.sv
module ssba_ctrl import ssba_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ssba_sts_t sts,
  output ssba_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_F_MUL, S_F_RD, S_F_CHK, S_A_CHK, S_A_REF, S_A_SCAN
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.act_free ? S_F_MUL : S_A_CHK;
        end
      end
      S_F_MUL: begin
        cmd.free_mul = 1'b1;
        state_nxt    = S_F_RD;
      end
      S_F_RD: begin
        cmd.free_rd = 1'b1;
        state_nxt   = S_F_CHK;
      end
      S_F_CHK: begin
        if (sts.out_space) begin
          cmd.free_emit = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_A_CHK: begin
        if (sts.refuse) begin
          state_nxt = S_A_REF;
        end else begin
          cmd.read_ptr = 1'b1;
          state_nxt    = S_A_SCAN;
        end
      end
      S_A_REF: begin
        if (sts.out_space) begin
          cmd.refuse_emit = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_A_SCAN: begin
        if (sts.cur_full) begin
          cmd.advance = 1'b1;
        end else if (sts.out_space) begin
          cmd.take = 1'b1;
          if (sts.take_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

>>> sv/ssba_dp.sv
module ssba_dp import ssba_pkg::*; #(
  parameter int MAP_WORDS   = MAP_WORDS_DEF,
  parameter int WORD_BITS   = WORD_BITS_DEF,
  parameter int MAX_REQUEST = MAX_REQUEST_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_action,
  input  logic [REQ_W-1:0]    in_request_size,
  input  logic [SLOT_W-1:0]   in_slot_to_free,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_last,
  input  ssba_cmd_t           cmd,
  output ssba_sts_t           sts
);

  localparam int PTR_W   = $clog2(MAP_WORDS);
  localparam int BIT_W   = $clog2(WORD_BITS);
  localparam int TOTAL   = MAP_WORDS * WORD_BITS;
  localparam int FREE_W  = $clog2(TOTAL);
  localparam int CMP_W   = (FREE_W > REQ_W) ? FREE_W : REQ_W;
  localparam int SUM_RAW = PTR_W + BIT_W + 1;
  localparam int SUM_W   = (SUM_RAW > SLOT_W) ? SUM_RAW : SLOT_W;
  localparam int DIF_W   = SLOT_W + REQ_W;
  localparam int MUL_W   = 32;
  localparam int unsigned RECIP = ((1 << DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;

  // Control registers
  logic [PTR_W-1:0]  clr_r;
  logic [PTR_W-1:0]  ptr_r;
  logic [FREE_W-1:0] free_r;
  logic [REQ_W-1:0]  rem_r;
  logic              fresh_r;
  logic              out_valid_r;

  // Payload registers
  logic [SLOT_W-1:0]    victim_r;
  logic [SLOT_W-1:0]    w_r;
  logic [BIT_W-1:0]     b_r;
  logic                 inrange_r;
  logic [WORD_BITS-1:0] word_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic                 out_last_r;

  // Combinational
  logic [PTR_W-1:0]     ptr_wrap;
  logic [WORD_BITS-1:0] cur;
  logic [WORD_BITS-1:0] lowest;
  logic [BIT_W-1:0]     bit_idx;
  logic [SUM_W-1:0]     slot_wide;
  logic [MUL_W-1:0]     prod;
  logic [DIF_W-1:0]     diff;
  logic [WORD_BITS-1:0] free_mask;
  logic                 bad;
  logic                 emit;
  logic                 out_space;

  logic                 ram_we;
  logic [PTR_W-1:0]     ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [PTR_W-1:0]     ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  ssba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ptr_wrap = (ptr_r == PTR_W'(MAP_WORDS - 1)) ? '0 : ptr_r + 1'b1;

  // Working word: fresh read data or the copy updated by the last take
  assign cur    = fresh_r ? ram_rdata : word_r;
  assign lowest = ~cur & (cur + 1'b1);

  // Encode the isolated lowest clear bit
  always_comb begin
    bit_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (lowest[i]) bit_idx = bit_idx | BIT_W'(i);
    end
  end

  assign slot_wide = SUM_W'(ptr_r) * SUM_W'(WORD_BITS) + SUM_W'(bit_idx);

  // Slot to word: multiply by reciprocal, exact for 12-bit slots
  assign prod = MUL_W'(victim_r) * MUL_W'(RECIP);
  assign diff = DIF_W'(victim_r) - DIF_W'(w_r) * DIF_W'(WORD_BITS);

  assign free_mask = WORD_BITS'(1) << b_r;
  assign bad = (victim_r == '0) || !inrange_r || ((ram_rdata & free_mask) == '0);

  assign out_space = !out_valid_r || out_ready;
  assign emit      = cmd.take || cmd.refuse_emit || cmd.free_emit;

  // Map port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_r;
    ram_wdata = cur | lowest;
    if (cmd.clear) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = (clr_r == '0) ? WORD_BITS'(1) : '0;
    end else if (cmd.take) begin
      ram_we = 1'b1;
    end else if (cmd.free_emit && !bad) begin
      ram_we    = 1'b1;
      ram_waddr = w_r[PTR_W-1:0];
      ram_wdata = ram_rdata & ~free_mask;
    end
  end

  always_comb begin
    ram_re    = cmd.read_ptr || cmd.advance || cmd.free_rd;
    ram_raddr = ptr_r;
    if (cmd.advance) begin
      ram_raddr = ptr_wrap;
    end else if (cmd.free_rd) begin
      ram_raddr = w_r[PTR_W-1:0];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      ptr_r       <= '0;
      free_r      <= FREE_W'(TOTAL - 1);
      rem_r       <= '0;
      fresh_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) clr_r <= clr_r + 1'b1;
      if (cmd.advance) ptr_r <= ptr_wrap;
      if (cmd.load) rem_r <= in_request_size;
      if (cmd.read_ptr || cmd.advance) fresh_r <= 1'b1;
      if (cmd.take) begin
        rem_r   <= rem_r - 1'b1;
        free_r  <= free_r - 1'b1;
        fresh_r <= 1'b0;
      end
      if (cmd.free_emit && !bad) free_r <= free_r + 1'b1;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (cmd.load) victim_r <= in_slot_to_free;
    if (cmd.free_mul) w_r <= prod[DIV_SHIFT +: SLOT_W];
    if (cmd.free_rd) begin
      b_r       <= diff[BIT_W-1:0];
      inrange_r <= (w_r < SLOT_W'(MAP_WORDS));
    end
    if (cmd.take) word_r <= cur | lowest;
    if (cmd.take) begin
      out_slot_r   <= slot_wide[SLOT_W-1:0];
      out_status_r <= ST_OK;
      out_last_r   <= (rem_r == REQ_W'(1));
    end else if (cmd.refuse_emit) begin
      out_slot_r   <= '0;
      out_status_r <= ST_REFUSED;
      out_last_r   <= 1'b1;
    end else if (cmd.free_emit) begin
      out_slot_r   <= victim_r;
      out_status_r <= bad ? ST_NOT_USED : ST_OK;
      out_last_r   <= 1'b1;
    end
  end

  // Status
  assign sts.clr_last  = (clr_r == PTR_W'(MAP_WORDS - 1));
  assign sts.act_free  = (in_action == ACT_FREE);
  assign sts.refuse    = (rem_r == '0) || (rem_r > REQ_W'(MAX_REQUEST)) ||
                         (CMP_W'(free_r) < CMP_W'(rem_r));
  assign sts.cur_full  = (cur == '1);
  assign sts.take_last = (rem_r == REQ_W'(1));
  assign sts.out_space = out_space;

  assign out_valid  = out_valid_r;
  assign out_slot   = out_slot_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

`ifndef SYNTHESIS
  // Free count never exceeds the usable slots
  a_free_max: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= FREE_W'(TOTAL - 1))
    else $error("free count above usable slots");

  // A result is only loaded when the output stage can take it
  a_emit_space: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_space)
    else $error("result loaded over a waiting result");

  // At most one result source per cycle
  a_emit_one: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.take, cmd.refuse_emit, cmd.free_emit}))
    else $error("two result sources at once");

  // A take claims a bit of a non-full word and uses one free slot
  a_take_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |-> (!sts.cur_full && rem_r != '0))
    else $error("take on full word or empty request");

  a_take_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> (free_r == $past(free_r) - 1'b1))
    else $error("free count not decremented on take");
`endif

endmodule

>>> sv/swap_slot_bitmap_allocator.sv
// Channel   | Dir | Words carried
// ----------+-----+--------------------------------------------------------
// in_chan   | in  | action, request_size, slot_to_free
// out_chan  | out | slot, status, last (one word per granted slot, else one)
//
// Free: word index, then bit index and map read, then an emitting check.
// Allocate: request check, read at the pointer, a step past each full map
// word on the map RAM's single read port, a take per granted slot. Refusal:
// request check, refusal emit. A reset sweep writes every map word before
// input is accepted. A stalled output holds the sequencer at each emit.
module swap_slot_bitmap_allocator import ssba_pkg::*; #(
  parameter int MAP_WORDS   = MAP_WORDS_DEF,
  parameter int WORD_BITS   = WORD_BITS_DEF,
  parameter int MAX_REQUEST = MAX_REQUEST_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  ssba_in_if.sink        in_chan,
  ssba_out_if.source     out_chan
);

  ssba_cmd_t cmd;
  ssba_sts_t sts;
  logic      ctl_in_ready;

  ssba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (ctl_in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ssba_dp #(
    .MAP_WORDS   (MAP_WORDS),
    .WORD_BITS   (WORD_BITS),
    .MAX_REQUEST (MAX_REQUEST)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_action       (in_chan.action),
    .in_request_size (in_chan.request_size),
    .in_slot_to_free (in_chan.slot_to_free),
    .out_ready       (out_chan.ready),
    .out_valid       (out_chan.valid),
    .out_slot        (out_chan.slot),
    .out_status      (out_chan.status),
    .out_last        (out_chan.last),
    .cmd             (cmd),
    .sts             (sts)
  );

  assign in_chan.ready = ctl_in_ready;

endmodule

>>> test/tb_swap_slot_bitmap_allocator.sv
`timescale 1ns / 100ps

module tb_swap_slot_bitmap_allocator;
  import ssba_pkg::*;

  localparam int NWORDS        = MAP_WORDS_DEF;
  localparam int WBITS         = WORD_BITS_DEF;
  localparam int MAXREQ        = MAX_REQUEST_DEF;
  localparam int TOTAL_SLOTS   = NWORDS * WBITS;
  localparam int MAX_WAIT      = 12;
  localparam int IDLE_LIMIT    = 3000;
  localparam int DRAIN_CYCLES  = 150;
  localparam int PRINT_LIMIT   = 30;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status;
    logic                last;
  } slot_result_t;

  logic clk;
  logic rst_n;

  ssba_in_if  in_if();
  ssba_out_if out_if();

  swap_slot_bitmap_allocator i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if.sink),
    .out_chan (out_if.source)
  );

  // Shadow copy of the allocator state
  logic [WBITS-1:0] used_map [NWORDS];
  logic [12:0]      free_count;
  int               next_word;

  slot_result_t      expected_results[$];
  logic [SLOT_W-1:0] held_slots[$];

  // Idle control: a fast side never waits between words
  bit in_fast;
  bit out_fast;

  int n_errors;
  int n_items;
  int n_results;
  int n_refused;
  int n_not_used;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int want, input int got);
    if (n_errors < PRINT_LIMIT)
      $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    n_errors++;
  endtask

  // Work out the result words caused by one accepted input word
  task automatic predict_allocator(input logic act, input logic [REQ_W-1:0] size,
                                   input logic [SLOT_W-1:0] victim);
    slot_result_t r;
    int w;
    int b;
    int tries;
    bit found;
    if (act == ACT_FREE) begin
      w = victim / WBITS;
      b = victim % WBITS;
      r.slot = victim;
      r.last = 1'b1;
      if (victim == 0 || w >= NWORDS || !used_map[w][b]) begin
        r.status = ST_NOT_USED;
      end else begin
        used_map[w][b] = 1'b0;
        free_count++;
        r.status = ST_OK;
      end
      expected_results.push_back(r);
    end else if (size == 0 || size > MAXREQ || free_count < size) begin
      r.slot   = '0;
      r.status = ST_REFUSED;
      r.last   = 1'b1;
      expected_results.push_back(r);
    end else begin
      for (int i = 0; i < size; i++) begin
        found = 1'b0;
        // next-fit: skip full words from the pointer, take the lowest clear bit
        for (tries = 0; tries < NWORDS && !found; tries++) begin
          w = next_word;
          for (int k = 0; k < WBITS; k++) begin
            if (!found && !used_map[w][k]) begin
              found = 1'b1;
              used_map[w][k] = 1'b1;
              r.slot = SLOT_W'(w * WBITS + k);
            end
          end
          if (!found) next_word = (w + 1) % NWORDS;
        end
        if (!found) begin
          // map ran dry despite the count; cannot happen while they agree
          r.slot   = '0;
          r.status = ST_REFUSED;
          r.last   = 1'b1;
          expected_results.push_back(r);
          free_count -= 13'(i);
          return;
        end
        r.status = ST_OK;
        r.last   = (i + 1 == size);
        expected_results.push_back(r);
        held_slots.push_back(r.slot);
      end
      free_count -= 13'(size);
    end
  endtask

  // Present one word and hold it until accepted; valid stays high afterwards
  task automatic send_word(input logic act, input logic [REQ_W-1:0] size,
                           input logic [SLOT_W-1:0] victim);
    int gap;
    gap = in_fast ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.action       <= act;
    in_if.request_size <= size;
    in_if.slot_to_free <= victim;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    predict_allocator(act, size, victim);
    n_items++;
  endtask

  // Hold off the sender until every expected word has come back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic free_held_slot();
    int idx;
    logic [SLOT_W-1:0] s;
    idx = $urandom_range(0, held_slots.size() - 1);
    s = held_slots[idx];
    held_slots.delete(idx);
    send_word(ACT_FREE, REQ_W'($urandom), s);
  endtask

  // Extremes, zero and oversized refusals, bad frees and next-fit ordering
  task automatic test_directed();
    in_fast  = 1'b0;
    out_fast = 1'b0;
    send_word(ACT_ALLOC, 7'd1, SLOT_W'($urandom));
    send_word(ACT_ALLOC, 7'(MAXREQ), '1);
    send_word(ACT_ALLOC, 7'd0, SLOT_W'($urandom));
    send_word(ACT_ALLOC, 7'(MAXREQ + 1), SLOT_W'($urandom));
    send_word(ACT_ALLOC, '1, '0);
    send_word(ACT_FREE, '1, '0);                 // reserved slot
    send_word(ACT_FREE, '0, '1);                 // top slot, never granted
    send_word(ACT_FREE, REQ_W'($urandom), 12'd5);
    send_word(ACT_FREE, REQ_W'($urandom), 12'd5); // double free
    drain_results();
    in_fast  = 1'b1;
    out_fast = 1'b1;
    // pointer has moved past word 0, so slot 5 is not reused yet
    send_word(ACT_ALLOC, 7'd1, SLOT_W'($urandom));
    send_word(ACT_FREE, REQ_W'($urandom), 12'(WBITS));
    send_word(ACT_FREE, REQ_W'($urandom), 12'(WBITS + 1));
    send_word(ACT_ALLOC, 7'd3, SLOT_W'($urandom));
    out_fast = 1'b0;
    send_word(ACT_ALLOC, 7'd2, '0);
    in_fast  = 1'b0;
    out_fast = 1'b1;
    send_word(ACT_FREE, 7'(MAXREQ), 12'd1);
    send_word(ACT_ALLOC, 7'd1, SLOT_W'($urandom));
  endtask

  // Mixed allocate and free traffic, mostly well-formed
  task automatic test_random_mix(input int count);
    int pick;
    int sel;
    logic [REQ_W-1:0] size;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        in_fast  = ($urandom_range(0, 3) == 0);
        out_fast = ($urandom_range(0, 3) == 0);
      end
      if (i % 97 == 96) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 45 && held_slots.size() > 0) begin
        free_held_slot();
      end else if (pick < 52) begin
        send_word(ACT_FREE, REQ_W'($urandom), SLOT_W'($urandom));
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 80)
          size = REQ_W'($urandom_range(1, 8));
        else if (sel < 95)
          size = REQ_W'($urandom_range(9, MAXREQ));
        else if (sel < 97)
          size = '0;
        else
          size = REQ_W'($urandom_range(MAXREQ + 1, (1 << REQ_W) - 1));
        send_word(ACT_ALLOC, size, SLOT_W'($urandom));
      end
    end
  endtask

  // Fill the whole map, hit the short refusal, then refill scattered holes
  task automatic test_exhaust();
    in_fast  = 1'b0;
    out_fast = 1'b1;
    while (free_count >= MAXREQ)
      send_word(ACT_ALLOC, REQ_W'($urandom_range(33, MAXREQ)), SLOT_W'($urandom));
    out_fast = 1'b0;
    send_word(ACT_ALLOC, REQ_W'(free_count + 1), SLOT_W'($urandom));
    if (free_count > 0)
      send_word(ACT_ALLOC, REQ_W'(free_count), SLOT_W'($urandom));
    send_word(ACT_ALLOC, 7'd1, SLOT_W'($urandom));
    repeat (16) free_held_slot();
    drain_results();
    send_word(ACT_ALLOC, 7'd16, SLOT_W'($urandom));
    send_word(ACT_ALLOC, 7'd1, SLOT_W'($urandom));
    repeat (4) free_held_slot();
    send_word(ACT_ALLOC, 7'd4, SLOT_W'($urandom));
  endtask

  // Result side: random stalls, each word checked against the oldest expectation
  initial begin
    int stall;
    slot_result_t want;
    out_if.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = out_fast ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      n_results++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", -1, out_if.slot);
      end else begin
        want = expected_results.pop_front();
        if (out_if.slot !== want.slot)     report_mismatch("slot", want.slot, out_if.slot);
        if (out_if.status !== want.status) report_mismatch("status", want.status, out_if.status);
        if (out_if.last !== want.last)     report_mismatch("last", want.last, out_if.last);
        if (want.status == ST_REFUSED)  n_refused++;
        if (want.status == ST_NOT_USED) n_not_used++;
      end
    end
  end

  // Watchdog: too long without any word moving on either side
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.action       <= ACT_ALLOC;
    in_if.request_size <= '0;
    in_if.slot_to_free <= '0;
    for (int i = 0; i < NWORDS; i++) used_map[i] = '0;
    used_map[0][0] = 1'b1;
    free_count = 13'(TOTAL_SLOTS - 1);
    next_word  = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_mix(320);
    test_exhaust();

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d input words, checked %0d result words (%0d refusals, %0d bad frees)",
             n_items, n_results, n_refused, n_not_used);
    $display("Map filled to capacity and refilled; %0d mismatches", n_errors);
    if (n_errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
